// ===== hw/rtl/rbvr_pkg.sv =====
// Shared types and constants of the variable-rate ring reader.
// No dependencies; every other file but rbvr_out_if imports it.
`timescale 1ns / 1ps

package rbvr_pkg;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_PUSH    = 2'd1,
        CMD_END     = 2'd2,
        CMD_PULL    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FRAME     = 3'd0,
        ST_SILENCE   = 3'd1,
        ST_ENDED     = 3'd2,
        ST_PUSH_OK   = 3'd3,
        ST_PUSH_FULL = 3'd4,
        ST_DONE      = 3'd5
    } t_status;

    // Control half of a job handed from the front to the back.
    typedef struct packed {
        t_status status;
        logic    wr;
        logic    rd;
    } t_job_ctl;

    localparam int QUEUE_DEPTH = 4;
    localparam int RATE_BITS   = 20;
    localparam int RATE_FRAC   = 16;

endpackage

// ===== hw/rtl/rbvr_in_if.sv =====
// Input channel of the variable-rate ring reader: command, frame and rate.
// Depends on rbvr_pkg.
`timescale 1ns / 1ps

interface rbvr_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    import rbvr_pkg::*;

    logic                          valid;
    logic                          ready;
    t_cmd                          cmd;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic [RATE_BITS-1:0]          rate;

    modport source (output valid, output cmd, output in_left, output in_right,
                    output rate, input ready);
    modport sink   (input valid, input cmd, input in_left, input in_right,
                    input rate, output ready);
endinterface

// ===== hw/rtl/rbvr_out_if.sv =====
// Output channel of the variable-rate ring reader: samples and status.
// No dependencies.
`timescale 1ns / 1ps

interface rbvr_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic [2:0]                    status;

    modport source (output valid, output out_left, output out_right,
                    output status, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input status, output ready);
endinterface

// ===== hw/rtl/ring_buffer_variable_rate_reader.sv =====
// Top level of the stereo ring buffer with a variable-rate interpolating reader.
// Depends on rbvr_pkg, rbvr_in_if, rbvr_out_if, rbvr_front, rbvr_queue, rbvr_back.
//
// Commands are restart, push, end mark and pull; every command yields exactly
// one result. The front updates pointers, phase and flags in the cycle an item
// is accepted and hands a job through a four-entry queue to the back. The back
// owns the single-port frame memory: a pull holds the port for both of its
// frame reads before the next job is taken, every other command uses it once,
// so other commands sustain one item per cycle while the output is not stalled.
// A result passes the queue, the read, difference and multiply stages and the
// output register. No clearing pass follows reset.
`timescale 1ns / 1ps

module ring_buffer_variable_rate_reader #(
    parameter int FRAME_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rbvr_in_if.sink      i_in,
    rbvr_out_if.source   o_out
);
    import rbvr_pkg::*;

    localparam int ADDR_BITS = $clog2(FRAME_DEPTH);
    localparam int DATA_BITS = 2 * ADDR_BITS + PHASE_BITS + 2 * SAMPLE_BITS;
    localparam int CTL_BITS  = $bits(t_job_ctl);
    localparam int JOB_BITS  = CTL_BITS + DATA_BITS;

    logic                 q_full, q_push, q_pop, q_valid;
    t_job_ctl             f_ctl, b_ctl;
    logic [DATA_BITS-1:0] f_data;
    logic [JOB_BITS-1:0]  q_head;

    rbvr_front #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_ctl    (f_ctl),
        .o_data   (f_data)
    );

    rbvr_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_data}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign b_ctl = t_job_ctl'(q_head[DATA_BITS +: CTL_BITS]);

    rbvr_back #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_ctl   (b_ctl),
        .i_data  (q_head[DATA_BITS-1:0]),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/rbvr_front.sv =====
// Front of the ring reader: accepts items, keeps pointers, phase and flags,
// and emits one job per item. Depends on rbvr_pkg and rbvr_in_if.
`timescale 1ns / 1ps

module rbvr_front #(
    parameter int FRAME_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16,
    localparam int ADDR_BITS  = $clog2(FRAME_DEPTH),
    localparam int DATA_BITS  = 2 * ADDR_BITS + PHASE_BITS + 2 * SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbvr_in_if.sink               i_in,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output rbvr_pkg::t_job_ctl    o_ctl,
    output logic [DATA_BITS-1:0]  o_data
);
    import rbvr_pkg::*;

    localparam int CNT_BITS = $clog2(2 * FRAME_DEPTH);
    localparam int CNT_MOD  = 2 * FRAME_DEPTH;
    localparam int SUM_BITS = (PHASE_BITS > 16) ? PHASE_BITS + 5 : 21;
    localparam int SH_L     = (PHASE_BITS >= RATE_FRAC) ? PHASE_BITS - RATE_FRAC : 0;
    localparam int SH_R     = (PHASE_BITS < RATE_FRAC) ? RATE_FRAC - PHASE_BITS : 0;

    logic [CNT_BITS-1:0]   r_wr_cnt, n_wr_cnt;
    logic [CNT_BITS-1:0]   r_rd_cnt, n_rd_cnt;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic                  r_end_seen, n_end_seen;
    logic                  r_active, n_active;

    logic                  accept;
    logic [CNT_BITS:0]     diff;
    logic [CNT_BITS-1:0]   fill;
    logic                  full;
    logic [ADDR_BITS-1:0]  rd_pos, rd_pos1, wr_pos;
    logic [ADDR_BITS:0]    rd_nxt;
    logic [CNT_BITS:0]     wr_inc, rd_adv;
    logic [SUM_BITS-1:0]   scaled, sum, step;
    logic [CNT_BITS-1:0]   step_c;
    t_job_ctl              ctl;
    logic [ADDR_BITS-1:0]  addr0;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_q_push   = accept;

    always_comb begin
        diff = {1'b0, r_wr_cnt} - {1'b0, r_rd_cnt};
        fill = diff[CNT_BITS] ? CNT_BITS'(diff + (CNT_BITS + 1)'(CNT_MOD))
                              : diff[CNT_BITS-1:0];
        full = fill >= CNT_BITS'(FRAME_DEPTH);

        rd_pos  = (r_rd_cnt >= CNT_BITS'(FRAME_DEPTH))
                ? ADDR_BITS'(r_rd_cnt - CNT_BITS'(FRAME_DEPTH)) : ADDR_BITS'(r_rd_cnt);
        rd_nxt  = {1'b0, rd_pos} + (ADDR_BITS + 1)'(1);
        rd_pos1 = (rd_nxt == (ADDR_BITS + 1)'(FRAME_DEPTH)) ? '0 : rd_nxt[ADDR_BITS-1:0];
        wr_pos  = (r_wr_cnt >= CNT_BITS'(FRAME_DEPTH))
                ? ADDR_BITS'(r_wr_cnt - CNT_BITS'(FRAME_DEPTH)) : ADDR_BITS'(r_wr_cnt);

        wr_inc = {1'b0, r_wr_cnt} + (CNT_BITS + 1)'(1);
        if (wr_inc == (CNT_BITS + 1)'(CNT_MOD)) begin
            wr_inc = '0;
        end

        scaled = (SUM_BITS'(i_in.rate) << SH_L) >> SH_R;
        sum    = SUM_BITS'(r_phase) + scaled;
        step   = sum >> PHASE_BITS;
        step_c = (step > SUM_BITS'(fill)) ? fill : CNT_BITS'(step);
        rd_adv = {1'b0, r_rd_cnt} + {1'b0, step_c};
        if (rd_adv >= (CNT_BITS + 1)'(CNT_MOD)) begin
            rd_adv = rd_adv - (CNT_BITS + 1)'(CNT_MOD);
        end

        n_wr_cnt   = r_wr_cnt;
        n_rd_cnt   = r_rd_cnt;
        n_phase    = r_phase;
        n_end_seen = r_end_seen;
        n_active   = r_active;
        ctl        = '{status: ST_DONE, wr: 1'b0, rd: 1'b0};
        addr0      = rd_pos;

        unique case (i_in.cmd)
            CMD_RESTART: begin
                n_wr_cnt   = '0;
                n_rd_cnt   = '0;
                n_phase    = '0;
                n_end_seen = 1'b0;
                n_active   = 1'b1;
            end
            CMD_PUSH: begin
                addr0 = wr_pos;
                if (full) begin
                    ctl.status = ST_PUSH_FULL;
                end else begin
                    ctl.status = ST_PUSH_OK;
                    ctl.wr     = 1'b1;
                    n_wr_cnt   = wr_inc[CNT_BITS-1:0];
                end
            end
            CMD_END: begin
                n_end_seen = 1'b1;
            end
            CMD_PULL: begin
                priority if (!r_active) begin
                    ctl.status = ST_ENDED;
                end else if (fill < CNT_BITS'(2)) begin
                    if (r_end_seen) begin
                        n_active   = 1'b0;
                        ctl.status = ST_ENDED;
                    end else begin
                        ctl.status = ST_SILENCE;
                    end
                end else begin
                    ctl.status = ST_FRAME;
                    ctl.rd     = 1'b1;
                    n_phase    = sum[PHASE_BITS-1:0];
                    n_rd_cnt   = rd_adv[CNT_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_ctl  = ctl;
    assign o_data = {addr0, rd_pos1, r_phase, i_in.in_left, i_in.in_right};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt   <= '0;
            r_rd_cnt   <= '0;
            r_phase    <= '0;
            r_end_seen <= 1'b0;
            r_active   <= 1'b0;
        end else if (accept) begin
            r_wr_cnt   <= n_wr_cnt;
            r_rd_cnt   <= n_rd_cnt;
            r_phase    <= n_phase;
            r_end_seen <= n_end_seen;
            r_active   <= n_active;
        end
    end

endmodule

// ===== hw/rtl/rbvr_queue.sv =====
// Short job queue between the front and the back of the ring reader.
// Depends on rbvr_pkg for its depth.
`timescale 1ns / 1ps

module rbvr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import rbvr_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wp, n_wp;
    logic [PTR_BITS-1:0] r_rp, n_rp;
    logic [PTR_BITS:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = r_count == (PTR_BITS + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp    = do_push ? r_wp + PTR_BITS'(1) : r_wp;
        n_rp    = do_pop ? r_rp + PTR_BITS'(1) : r_rp;
        n_count = r_count + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/rbvr_back.sv =====
// Back of the ring reader: frame memory, two-read issue, blend pipeline and
// output register. Depends on rbvr_pkg and rbvr_out_if.
`timescale 1ns / 1ps

module rbvr_back #(
    parameter int FRAME_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16,
    localparam int ADDR_BITS  = $clog2(FRAME_DEPTH),
    localparam int DATA_BITS  = 2 * ADDR_BITS + PHASE_BITS + 2 * SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rbvr_pkg::t_job_ctl    i_ctl,
    input  logic [DATA_BITS-1:0]  i_data,
    output logic                  o_pop,
    rbvr_out_if.source            o_out
);
    import rbvr_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int P    = PHASE_BITS;
    localparam int PW   = S + P + 1;

    logic [2*S-1:0]       mem [FRAME_DEPTH];

    logic [ADDR_BITS-1:0] addr0, addr1, rd_addr;
    logic [P-1:0]         job_phase;
    logic [2*S-1:0]       wdata;
    logic                 en, we, token;
    logic                 r_sub;

    // read stage
    logic                 r_a_valid;
    t_status              r_a_status;
    logic [P-1:0]         r_a_phase;
    logic [2*S-1:0]       r_rdata, r_hold;

    // difference stage
    logic                 r_b_valid;
    t_status              r_b_status;
    logic [P-1:0]         r_b_phase;
    logic [S-1:0]         r_b_s0_l, r_b_s0_r;
    logic [S:0]           r_b_mag_l, r_b_mag_r;
    logic                 r_b_neg_l, r_b_neg_r;

    // multiply stage
    logic                 r_c_valid;
    t_status              r_c_status;
    logic [S-1:0]         r_c_s0_l, r_c_s0_r;
    logic [S:0]           r_c_t_l, r_c_t_r;
    logic                 r_c_neg_l, r_c_neg_r;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [S-1:0]         r_out_left, r_out_right;

    logic [S:0]           d_l, d_r;
    logic [PW-1:0]        prod_l, prod_r;
    logic [S:0]           y_l, y_r;

    assign addr0     = i_data[2*S+P+ADDR_BITS +: ADDR_BITS];
    assign addr1     = i_data[2*S+P +: ADDR_BITS];
    assign job_phase = i_data[2*S +: P];
    assign wdata     = i_data[2*S-1:0];

    assign en      = !r_out_valid || o_out.ready;
    assign rd_addr = r_sub ? addr1 : addr0;
    assign we      = en && i_valid && i_ctl.wr;
    assign token   = i_valid && (!i_ctl.rd || r_sub);
    assign o_pop   = en && token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (en && i_valid && i_ctl.rd) begin
            r_sub <= !r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr0] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rdata <= mem[rd_addr];
            r_hold  <= r_rdata;
        end
    end

    always_comb begin
        d_l = {r_rdata[2*S-1], r_rdata[2*S-1:S]} - {r_hold[2*S-1], r_hold[2*S-1:S]};
        d_r = {r_rdata[S-1], r_rdata[S-1:0]} - {r_hold[S-1], r_hold[S-1:0]};
        prod_l = PW'(r_b_mag_l) * PW'(r_b_phase) + (PW'(1) << (P - 1));
        prod_r = PW'(r_b_mag_r) * PW'(r_b_phase) + (PW'(1) << (P - 1));
        y_l = r_c_neg_l ? {r_c_s0_l[S-1], r_c_s0_l} - r_c_t_l
                        : {r_c_s0_l[S-1], r_c_s0_l} + r_c_t_l;
        y_r = r_c_neg_r ? {r_c_s0_r[S-1], r_c_s0_r} - r_c_t_r
                        : {r_c_s0_r[S-1], r_c_s0_r} + r_c_t_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= token;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_status <= i_ctl.status;
            r_a_phase  <= job_phase;

            r_b_status <= r_a_status;
            r_b_phase  <= r_a_phase;
            r_b_s0_l   <= r_hold[2*S-1:S];
            r_b_s0_r   <= r_hold[S-1:0];
            r_b_neg_l  <= d_l[S];
            r_b_neg_r  <= d_r[S];
            r_b_mag_l  <= d_l[S] ? -d_l : d_l;
            r_b_mag_r  <= d_r[S] ? -d_r : d_r;

            r_c_status <= r_b_status;
            r_c_s0_l   <= r_b_s0_l;
            r_c_s0_r   <= r_b_s0_r;
            r_c_neg_l  <= r_b_neg_l;
            r_c_neg_r  <= r_b_neg_r;
            r_c_t_l    <= prod_l[P +: S+1];
            r_c_t_r    <= prod_r[P +: S+1];

            r_out_status <= r_c_status;
            r_out_left   <= (r_c_status == ST_FRAME) ? y_l[S-1:0] : '0;
            r_out_right  <= (r_c_status == ST_FRAME) ? y_r[S-1:0] : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.out_left  = r_out_left;
    assign o_out.out_right = r_out_right;

endmodule
